// ----- rtl/value_interning_table_core_assert.svh -----
// Assertion macros used by the table core datapath.
`ifndef VALUE_INTERNING_TABLE_CORE_ASSERT_SVH
`define VALUE_INTERNING_TABLE_CORE_ASSERT_SVH
// same-cycle implication
`define VIT_ASSERT_NOW(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define VIT_ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ----- rtl/vit_pkg.sv -----
// Shared codes and controller/datapath interface types for the interning table.
package vit_pkg;
   localparam logic [1:0] CMD_ADD      = 2'd0;
   localparam logic [1:0] CMD_FIND_VAL = 2'd1;
   localparam logic [1:0] CMD_FIND_ID  = 2'd2;
   localparam logic [1:0] CMD_CLEAR    = 2'd3;

   localparam logic [1:0] ST_NEW   = 2'd0;
   localparam logic [1:0] ST_FOUND = 2'd1;
   localparam logic [1:0] ST_MISS  = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef enum logic [1:0] {
      RS_ZERO,
      RS_HIT,
      RS_NEW,
      RS_BYID
   } rsp_sel_type;

   typedef struct packed {
      logic        load;     // latch request beat, init search bounds
      logic        srch_rd;  // read sorted entry at mid
      logic        srch_upd; // narrow bounds from read data
      logic        chk_rd;   // read sorted entry at lower bound
      logic        sh_init;  // shift pointer to entry count
      logic        sh_rd;    // read sorted entry j-1
      logic        sh_wr;    // write read data to entry j, step down
      logic        ins;      // place new entry, bump count
      logic        id_rd;    // read value by id
      logic        clr;      // empty the table
      logic        rsp;      // emit result beat
      logic [1:0]  rsp_status;
      rsp_sel_type rsp_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic srch_done;
      logic hit;
      logic full;
      logic id_ok;
      logic sh_done;
   } dp_status_type;
endpackage

// ----- rtl/value_interning_table_core.sv -----
// Top level: value interning table, sorted store with id back-map.
// Clear answers straight from idle; find-by-id reads the id store, then answers.
// Add / find-by-value: at most ceil(log2(count+1)) binary-search probes, each a
//   read at mid then a bound update, then a check read; a new value then shifts
//   (count - pos) entries and inserts, all through the single-port-pair RAM.
// One command in flight; busy drops in the strobe cycle, next start taken there.
// Receiver cannot stall. Reset (sync, high) empties the table; RAMs keep contents.
module value_interning_table_core import vit_pkg::*; #(
   parameter int ENTRIES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_cmd,
   input  logic signed [31:0] req_value,
   input  logic [7:0]         req_id,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_result_id,
   output logic signed [31:0] rsp_result_value
);
   ctrl_cmd_type  cmd;
   dp_status_type stat;

   // sequencer: accepts a beat when idle, steps search/shift/insert
   vit_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_cmd(req_cmd),
      .stat(stat), .cmd(cmd), .busy(busy)
   );

   // storage, bounds and the registered result beat
   vit_dp #(.ENTRIES(ENTRIES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .req_value(req_value), .req_id(req_id), .stat(stat),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_result_id(rsp_result_id), .rsp_result_value(rsp_result_value)
   );
endmodule

// ----- rtl/vit_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module vit_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/vit_ctrl.sv -----
// Command sequencer: search, shift-insert and lookup control.
module vit_ctrl import vit_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [1:0]    req_cmd,
   input  dp_status_type stat,
   output ctrl_cmd_type  cmd,
   output logic          busy
);
   typedef enum logic [2:0] {
      IDLE, SRCH, SCMP, CHK, SHIFT, SHWR, INSERT, IDWAIT
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] op_ff, op_in;

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      cmd            = '0;
      cmd.rsp_sel    = RS_ZERO;
      cmd.rsp_status = ST_NEW;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               op_in    = req_cmd;
               unique case (req_cmd)
                  CMD_ADD, CMD_FIND_VAL: state_in = SRCH;
                  CMD_FIND_ID:           state_in = IDWAIT;
                  default: begin
                     cmd.clr = 1'b1;
                     cmd.rsp = 1'b1;
                  end
               endcase
            end
         end
         SRCH: begin
            if (stat.srch_done) begin
               cmd.chk_rd = 1'b1;
               state_in   = CHK;
            end else begin
               cmd.srch_rd = 1'b1;
               state_in    = SCMP;
            end
         end
         SCMP: begin
            cmd.srch_upd = 1'b1;
            state_in     = SRCH;
         end
         CHK: begin
            priority if (stat.hit) begin
               cmd.rsp = 1'b1; cmd.rsp_status = ST_FOUND; cmd.rsp_sel = RS_HIT;
               state_in = IDLE;
            end else if (op_ff == CMD_FIND_VAL) begin
               cmd.rsp = 1'b1; cmd.rsp_status = ST_MISS;
               state_in = IDLE;
            end else if (stat.full) begin
               cmd.rsp = 1'b1; cmd.rsp_status = ST_FULL;
               state_in = IDLE;
            end else begin
               cmd.sh_init = 1'b1;
               state_in    = SHIFT;
            end
         end
         SHIFT: begin
            if (stat.sh_done) begin
               state_in = INSERT;
            end else begin
               cmd.sh_rd = 1'b1;
               state_in  = SHWR;
            end
         end
         SHWR: begin
            cmd.sh_wr = 1'b1;
            state_in  = SHIFT;
         end
         INSERT: begin
            cmd.ins = 1'b1; cmd.rsp = 1'b1;
            cmd.rsp_status = ST_NEW; cmd.rsp_sel = RS_NEW;
            state_in = IDLE;
         end
         IDWAIT: begin
            cmd.rsp = 1'b1;
            if (stat.id_ok) begin
               cmd.rsp_status = ST_FOUND; cmd.rsp_sel = RS_BYID;
            end else begin
               cmd.rsp_status = ST_MISS;
            end
            state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
      if (state_ff == IDLE && start && req_cmd == CMD_FIND_ID) begin
         cmd.id_rd = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         op_ff    <= CMD_ADD;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   assign busy = (state_ff != IDLE);
endmodule

// ----- rtl/vit_dp.sv -----
// Datapath: sorted store, id store, search bounds, shift pointer, result beat.
module vit_dp import vit_pkg::*; #(
   parameter int ENTRIES = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   input  logic signed [31:0]  req_value,
   input  logic [7:0]          req_id,
   output dp_status_type       stat,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [7:0]          rsp_result_id,
   output logic signed [31:0]  rsp_result_value
);
   localparam int AW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);
   localparam logic [CW-1:0] ONE        = CW'(1);

   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      lo_ff, lo_in, hi_ff, hi_in, j_ff, j_in;
   logic signed [31:0] val_ff;
   logic [7:0]         id_ff;
   logic [CW:0]        sum;
   logic [CW-1:0]      mid;

   logic [39:0]        s_wdata, s_rdata;
   logic [AW-1:0]      s_waddr, s_raddr;
   logic               s_we;
   logic [31:0]        v_rdata;
   logic [AW-1:0]      id_addr;
   logic signed [31:0] rd_val;

   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [7:0]         rsp_id_ff;
   logic signed [31:0] rsp_value_ff;

   assign sum     = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = sum[CW:1];
   assign rd_val  = $signed(s_rdata[39:8]);
   assign id_addr = AW'(cmd.id_rd ? req_id : id_ff);

   always_comb begin
      priority if (cmd.srch_rd)  s_raddr = mid[AW-1:0];
      else if (cmd.sh_rd)        s_raddr = AW'(j_ff - ONE);
      else                       s_raddr = lo_ff[AW-1:0];
      s_we    = cmd.sh_wr | cmd.ins;
      s_waddr = cmd.ins ? lo_ff[AW-1:0] : j_ff[AW-1:0];
      s_wdata = cmd.ins ? {val_ff, 8'(count_ff)} : s_rdata;
   end

   vit_ram #(.WIDTH(40), .DEPTH(ENTRIES)) u_sorted (
      .clock(clock), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
      .raddr(s_raddr), .rdata(s_rdata)
   );

   vit_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_by_id (
      .clock(clock), .we(cmd.ins), .waddr(count_ff[AW-1:0]), .wdata(val_ff),
      .raddr(id_addr), .rdata(v_rdata)
   );

   always_comb begin
      count_in = count_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      j_in     = j_ff;
      if (cmd.load) begin
         lo_in = '0;
         hi_in = count_ff;
      end
      if (cmd.srch_upd) begin
         if (rd_val < val_ff) lo_in = mid + ONE;
         else                 hi_in = mid;
      end
      if (cmd.sh_init) j_in = count_ff;
      if (cmd.sh_wr)   j_in = j_ff - ONE;
      if (cmd.ins)     count_in = count_ff + ONE;
      if (cmd.clr)     count_in = '0;
   end

   always_comb begin
      stat.srch_done = (lo_ff >= hi_ff);
      stat.hit       = (lo_ff < count_ff) && (rd_val == val_ff);
      stat.full      = (count_ff == FULL_COUNT);
      stat.id_ok     = ({24'd0, id_ff} < {{(32-CW){1'b0}}, count_ff});
      stat.sh_done   = (j_ff == lo_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.rsp;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      j_ff  <= j_in;
      if (cmd.load) begin
         val_ff <= req_value;
         id_ff  <= req_id;
      end
      if (cmd.rsp) begin
         rsp_status_ff <= cmd.rsp_status;
         unique case (cmd.rsp_sel)
            RS_HIT:  begin rsp_id_ff <= s_rdata[7:0];  rsp_value_ff <= val_ff; end
            RS_NEW:  begin rsp_id_ff <= 8'(count_ff);  rsp_value_ff <= val_ff; end
            RS_BYID: begin rsp_id_ff <= id_ff; rsp_value_ff <= $signed(v_rdata); end
            default: begin rsp_id_ff <= '0;            rsp_value_ff <= '0;     end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_id    = rsp_id_ff;
   assign rsp_result_value = rsp_value_ff;

`include "value_interning_table_core_assert.svh"
   `VIT_ASSERT_NOW(a_count_cap, clock, reset, 1'b1, count_ff <= FULL_COUNT, "count over cap")
   `VIT_ASSERT_NEXT(a_ins_bump, clock, reset, cmd.ins, count_ff == $past(count_ff) + ONE, "ins")
   `VIT_ASSERT_NOW(a_no_ins_full, clock, reset, cmd.ins, !stat.full, "insert into full table")
endmodule

// ----- test/value_interning_table_core_test.sv -----
// Self-checking bench for the value interning table core: add, find and clear beats.
`timescale 1ns / 100ps

module value_interning_table_core_test;
   import vit_pkg::*;

   localparam int ENTRIES   = 256;
   localparam int WDOG_MAX  = 20000;  // worst add: ~9 probes + 256-entry shift
   localparam int N_RANDOM  = 420;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] value;
      logic [7:0]         id;
   } cmd_beat_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [7:0]         rid;
      logic signed [31:0] rval;
   } answer_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_cmd = CMD_CLEAR;
   logic signed [31:0] req_value = '0;
   logic [7:0]         req_id = '0;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic [7:0]         rsp_result_id;
   logic signed [31:0] rsp_result_value;

   value_interning_table_core #(.ENTRIES(ENTRIES)) uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Table shadow: the value_by_id back-map plus count is enough; the
   // sorted order only matters inside the block, lookups here are linear.
   // ---------------------------------------------------------------
   logic signed [31:0] id_to_value [ENTRIES];
   int                 table_count = 0;

   cmd_beat_type pending_cmds[$];
   answer_type   expected_answers[$];
   logic signed [31:0] used_values[$];   // pool for repeats and hits
   int  fail_count = 0;
   int  beats_sent = 0, beats_checked = 0;
   int  hits_seen = 0, full_seen = 0, miss_seen = 0;
   bit  stim_done = 1'b0;

   function automatic answer_type intern_step(cmd_beat_type b);
      answer_type a;
      int         hit;
      a   = '{status: ST_MISS, rid: '0, rval: '0};
      hit = -1;
      case (b.cmd)
         CMD_ADD, CMD_FIND_VAL: begin
            for (int i = 0; i < table_count; i++)
               if (id_to_value[i] == b.value) hit = i;
            if (hit >= 0)
               a = '{status: ST_FOUND, rid: hit[7:0], rval: b.value};
            else if (b.cmd == CMD_FIND_VAL)
               a.status = ST_MISS;
            else if (table_count >= ENTRIES)
               a.status = ST_FULL;
            else begin
               id_to_value[table_count] = b.value;
               a = '{status: ST_NEW, rid: table_count[7:0], rval: b.value};
               table_count++;
            end
         end
         CMD_FIND_ID: begin
            if (int'(b.id) < table_count)
               a = '{status: ST_FOUND, rid: b.id, rval: id_to_value[b.id]};
         end
         default: begin
            table_count = 0;
            a.status    = ST_NEW;
         end
      endcase
      return a;
   endfunction

   // ---------------------------------------------------------------
   // Driver: one beat from the queue, random gaps between beats.
   // Start only rises/falls once per edge; accept is start && !busy.
   // ---------------------------------------------------------------
   int   gap_left = 0;
   logic busy_at_edge;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;         // back-to-back stretches
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);  // occasional long idle
   endfunction

   task automatic drive_next();
      cmd_beat_type b;
      b = pending_cmds.pop_front();
      req_cmd   <= b.cmd;
      req_value <= b.value;
      req_id    <= b.id;
      start     <= 1'b1;
      gap_left   = pick_gap();
   endtask

   always @(negedge clock) begin
      if (!reset) begin
         if (start && !busy_at_edge) begin
            // previous beat taken at the last rising edge
            if (gap_left == 0 && pending_cmds.size() > 0) begin
               drive_next();
            end else begin
               start <= 1'b0;
            end
         end else if (!start) begin
            if (gap_left > 0)
               gap_left--;
            else if (pending_cmds.size() > 0)
               drive_next();
         end
      end
   end

   always @(posedge clock) begin
      busy_at_edge <= busy;
      if (!reset && start && !busy) begin
         expected_answers.push_back(intern_step('{cmd: req_cmd, value: req_value,
                                                  id: req_id}));
         beats_sent++;
      end
   end

   // ---------------------------------------------------------------
   // Monitor: every strobe must match the oldest expectation.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid) begin
         if (expected_answers.size() == 0) begin
            $error("result beat with nothing expected: status %0d id %0d value %0d",
                   rsp_status, rsp_result_id, rsp_result_value);
            fail_count++;
         end else begin
            e = expected_answers.pop_front();
            beats_checked++;
            if (e.status == ST_FOUND) hits_seen++;
            if (e.status == ST_FULL)  full_seen++;
            if (e.status == ST_MISS)  miss_seen++;
            if (rsp_status !== e.status) begin
               $error("status: expected %0d actual %0d", e.status, rsp_status);
               fail_count++;
            end
            if (rsp_result_id !== e.rid) begin
               $error("result_id: expected %0d actual %0d", e.rid, rsp_result_id);
               fail_count++;
            end
            if (rsp_result_value !== e.rval) begin
               $error("result_value: expected %0d actual %0d", e.rval, rsp_result_value);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: cycles with no beat accepted on either side.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || stim_done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("timeout: no beat for %0d cycles", WDOG_MAX);
         $display("FAIL value_interning_table_core");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   function automatic logic signed [31:0] rand_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return 32'sh8000_0000 + $urandom_range(0, 3);
      if (r < 4) return 32'sh7fff_fffc + $urandom_range(0, 3);
      if (r < 6) return $signed(32'($urandom_range(0, 20))) - 10;
      return $signed($urandom());
   endfunction

   task automatic queue_cmd(logic [1:0] c, logic signed [31:0] v, logic [7:0] i);
      pending_cmds.push_back('{cmd: c, value: v, id: i});
      if (c == CMD_ADD) used_values.push_back(v);
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() > 0 || start || expected_answers.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      logic signed [31:0] v;
      int r;
      repeat (7) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // directed: empty table lookups, extremes, duplicates, clear
      queue_cmd(CMD_FIND_VAL, 32'sd0, 8'd0);
      queue_cmd(CMD_FIND_ID,  32'sd0, 8'd0);
      queue_cmd(CMD_ADD, 32'sh7fff_ffff, 8'd0);
      queue_cmd(CMD_ADD, 32'sh8000_0000, 8'd0);
      queue_cmd(CMD_ADD, 32'sd0, 8'd0);
      queue_cmd(CMD_ADD, -32'sd1, 8'd0);
      queue_cmd(CMD_ADD, 32'sh8000_0000, 8'hff);
      queue_cmd(CMD_FIND_VAL, 32'sh7fff_ffff, 8'd0);
      queue_cmd(CMD_FIND_VAL, 32'sd1, 8'd0);
      queue_cmd(CMD_FIND_ID,  32'sd0, 8'd3);
      queue_cmd(CMD_FIND_ID,  32'sd0, 8'd4);
      queue_cmd(CMD_FIND_ID,  32'sd0, 8'hff);
      queue_cmd(CMD_CLEAR, 32'shffff_ffff, 8'hff);
      queue_cmd(CMD_FIND_ID,  32'sd0, 8'd0);
      queue_cmd(CMD_FIND_VAL, 32'sd0, 8'd0);
      queue_cmd(CMD_ADD, 32'sh5555_aaaa, 8'h55);
      queue_cmd(CMD_FIND_ID, 32'sd0, 8'd0);
      queue_cmd(CMD_CLEAR, 32'sd0, 8'd0);
      wait_drained();

      // fill to capacity with descending values so every add shifts the
      // whole sorted array, then poke the full table
      for (int i = 0; i < ENTRIES; i++)
         queue_cmd(CMD_ADD, 32'sd1000000 - i * 7, 8'd0);
      queue_cmd(CMD_ADD, 32'sd5, 8'd0);             // table full
      queue_cmd(CMD_ADD, 32'sd1000000, 8'd0);       // present, still found
      queue_cmd(CMD_FIND_ID, 32'sd0, 8'hff);
      queue_cmd(CMD_FIND_VAL, 32'sd1000000 - 255 * 7, 8'd0);
      queue_cmd(CMD_CLEAR, 32'sd0, 8'd0);
      used_values.delete();

      // random: mostly adds/finds over a small live set, clears now and then
      for (int n = 0; n < N_RANDOM; n++) begin
         r = $urandom_range(0, 99);
         if (used_values.size() > 0 && $urandom_range(0, 1))
            v = used_values[$urandom_range(0, used_values.size() - 1)];
         else
            v = rand_value();
         if (r < 45)       queue_cmd(CMD_ADD, v, 8'($urandom()));
         else if (r < 70)  queue_cmd(CMD_FIND_VAL, v, 8'($urandom()));
         else if (r < 97)  queue_cmd(CMD_FIND_ID, v,
                                     $urandom_range(0, 3) == 0 ? 8'($urandom())
                                                               : 8'($urandom_range(0, 40)));
         else begin
            queue_cmd(CMD_CLEAR, v, 8'($urandom()));
            used_values.delete();
         end
      end
      wait_drained();
      repeat (20) @(posedge clock);
      stim_done = 1'b1;

      $display("sent %0d commands, checked %0d: %0d hits, %0d misses, %0d full answers",
               beats_sent, beats_checked, hits_seen, miss_seen, full_seen);
      if (fail_count == 0 && expected_answers.size() == 0)
         $display("PASS value_interning_table_core");
      else
         $display("FAIL value_interning_table_core");
      $finish;
   end

endmodule
